@@ hw/rtl/kmer_hash_table_engine_assert.svh @@
// Assertion macros shared by the k-mer hash table engine RTL.
`ifndef KMER_HASH_TABLE_ENGINE_ASSERT_SVH
`define KMER_HASH_TABLE_ENGINE_ASSERT_SVH
// Property that must hold whenever the block is out of reset.
`define KHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked at every clock edge, reset cycles included.
`define KHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ hw/rtl/kht_pkg.sv @@
// Shared types, constants and helper functions for the k-mer hash table engine.
package kht_pkg;
  localparam int unsigned TableDepthDefault = 4096;
  localparam int unsigned MaxBasesDefault   = 64;
  localparam logic [63:0] FnvOffset = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime  = 64'h00000100000001B3;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpFind   = 2'd1;
  localparam logic [1:0] OpExtend = 2'd2;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  localparam logic [0:0] RegKmerLength = 1'd0;
  localparam logic [0:0] RegTableLog   = 1'd1;

  typedef enum logic [2:0] {
    BK_IDLE, BK_HASH, BK_READ, BK_WAIT, BK_CHECK, BK_DONE
  } bk_state_t;

  // Request handed from the front part to the back part.
  typedef struct packed {
    logic        is_insert;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [2:0]  forward_code;
    logic [2:0]  backward_code;
    logic [6:0]  k;
    logic [4:0]  nbytes;
  } kht_req_t;

  // Top-aligned mask keeping the first k bases of a 128-bit key.
  function automatic logic [127:0] key_mask(input logic [6:0] k);
    logic [127:0] m;
    begin
      m = ~({128{1'b1}} >> {k, 1'b0});
      return m;
    end
  endfunction
endpackage

@@ hw/rtl/kht_front.sv @@
// Front part: clips and extends the key, classifies the request, queues it.
module kht_front import kht_pkg::*; #(
  parameter int unsigned MAX_BASES = MaxBasesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [2:0]  forward_code,
  input  logic [2:0]  backward_code,
  input  logic [1:0]  step_base,
  input  logic [6:0]  kmer_length,
  output logic        q_valid,
  input  logic        q_pop,
  output kht_req_t    q_head
);
  localparam int unsigned QDepth = 2;

  kht_req_t    q_mem_r [QDepth];
  logic        wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [6:0]  k;
  logic [127:0] key_c, key_s, m;
  logic [6:0]  p;
  kht_req_t    req;
  logic        push;

  always_comb begin
    k = kmer_length;
    if (k == 7'd0) k = 7'd1;
    if (k > 7'(MAX_BASES)) k = 7'(MAX_BASES);
    m = key_mask(k);
    key_c = {key_high, key_low} & m;
    p = k - 7'd1;
    key_s = key_c;
    if (op == OpExtend) begin
      key_s = (key_c << 2) & m;
      key_s = key_s | ({126'd0, step_base} << (7'd126 - {p[5:0], 1'b0}));
    end
    req.is_insert     = (op == OpInsert);
    req.key_high      = key_s[127:64];
    req.key_low       = key_s[63:0];
    req.forward_code  = forward_code;
    req.backward_code = backward_code;
    req.k             = k;
    req.nbytes        = 5'((k + 7'd3) >> 2);
  end

  assign in_stall = (cnt_r == 2'(QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= req;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  `include "kmer_hash_table_engine_assert.svh"
  `KHT_ASSERT(a_no_pop_empty, q_pop |-> q_valid, "queue popped while empty")
  `KHT_ASSERT(a_cnt_range, cnt_r <= 2'(QDepth), "queue count out of range")
  `KHT_ASSERT(a_cnt_step, (push && !q_pop) |=> cnt_r == $past(cnt_r) + 2'd1,
              "queue count did not grow on push")
endmodule

@@ hw/rtl/kht_back.sv @@
// Back part: FNV-1a hash, linear probe walk over the slot memory, result register.
module kht_back import kht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  kht_req_t    q_head,
  input  logic [3:0]  table_log_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [11:0] slot_index,
  output logic [2:0]  found_forward,
  output logic [2:0]  found_backward,
  output logic [63:0] next_key_high,
  output logic [63:0] next_key_low
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned LogW = $clog2(AW + 1) + 1;

  bk_state_t    st_r, st_nxt;
  kht_req_t     req_r;
  logic [63:0]  h_r, h_nxt;
  logic [63:0]  h_mix;
  logic [4:0]   bi_r, bi_nxt;
  logic [AW-1:0] idx_r, idx_nxt, mask_r;
  logic [CW-1:0] n_r, n_nxt, slots_r;
  logic         occ_rd_r;
  logic [63:0]  rk_hi_r, rk_lo_r;
  logic [2:0]   rf_r, rb_r;
  logic         occ_mem [TABLE_DEPTH];
  logic [63:0]  khi_mem [TABLE_DEPTH];
  logic [63:0]  klo_mem [TABLE_DEPTH];
  logic [2:0]   fw_mem  [TABLE_DEPTH];
  logic [2:0]   bw_mem  [TABLE_DEPTH];
  logic [AW:0]  clr_r;
  logic         clearing;
  logic [7:0]   byte_c;
  logic [127:0] km;
  logic         hit, wr_en, res_load;
  logic [1:0]   res_st;
  logic [AW-1:0] res_slot;
  logic [2:0]   res_f, res_b;
  logic [LogW-1:0] lg;

  assign clearing = !clr_r[AW];

  // Effective slot count and mask.
  always_comb begin
    lg = LogW'(table_log_size);
    if (lg == '0) lg = LogW'(1);
    if (lg > LogW'(AW)) lg = LogW'(AW);
  end

  always_comb begin
    byte_c = bi_r[3] ? req_r.key_low[8'(7 - bi_r[2:0]) * 8 +: 8]
                     : req_r.key_high[8'(7 - bi_r[2:0]) * 8 +: 8];
    km  = key_mask(req_r.k);
    hit = occ_rd_r && (({rk_hi_r, rk_lo_r} & km) == {req_r.key_high, req_r.key_low});
  end

  // The FNV prime is 2^40 + 0x1B3, so the multiply is a sum of shifted copies.
  assign h_mix = h_r ^ {56'd0, byte_c};

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (q_valid && !clearing) st_nxt = BK_HASH;
      BK_HASH:  if (bi_r == req_r.nbytes) st_nxt = BK_READ;
      BK_READ:  st_nxt = BK_WAIT;
      BK_WAIT:  st_nxt = BK_CHECK;
      BK_CHECK: begin
        if (req_r.is_insert) begin
          if (!occ_rd_r || n_r + CW'(1) == slots_r) st_nxt = BK_DONE;
          else st_nxt = BK_READ;
        end else begin
          if (!occ_rd_r || hit || n_r + CW'(1) == slots_r) st_nxt = BK_DONE;
          else st_nxt = BK_READ;
        end
      end
      BK_DONE:  if (!out_valid || !out_stall) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    q_pop = (st_r == BK_IDLE) && q_valid && !clearing;
    h_nxt = h_r; bi_nxt = bi_r; idx_nxt = idx_r; n_nxt = n_r;
    wr_en = 1'b0; res_load = 1'b0;
    res_st = StNotFound; res_slot = '0; res_f = '0; res_b = '0;
    case (st_r)
      BK_IDLE: begin
        h_nxt = FnvOffset; bi_nxt = '0; n_nxt = '0;
      end
      BK_HASH: begin
        if (bi_r != req_r.nbytes) begin
          h_nxt  = (h_mix << 40) + (h_mix << 8) + (h_mix << 7) + (h_mix << 5)
                 + (h_mix << 4) + (h_mix << 1) + h_mix;
          bi_nxt = bi_r + 5'd1;
        end else begin
          idx_nxt = h_r[AW-1:0] & mask_r;
        end
      end
      BK_CHECK: begin
        if (req_r.is_insert) begin
          if (!occ_rd_r) begin
            wr_en = 1'b1; res_load = 1'b1; res_st = StDone; res_slot = idx_r;
            res_f = req_r.forward_code; res_b = req_r.backward_code;
          end else if (n_r + CW'(1) == slots_r) begin
            res_load = 1'b1; res_st = StFull;
          end
        end else if (!occ_rd_r) begin
          res_load = 1'b1;
        end else if (hit) begin
          res_load = 1'b1; res_st = StDone; res_slot = idx_r; res_f = rf_r; res_b = rb_r;
        end else if (n_r + CW'(1) == slots_r) begin
          res_load = 1'b1;
        end
        idx_nxt = (idx_r + AW'(1)) & mask_r;
        n_nxt   = n_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_IDLE && q_pop) begin
      req_r   <= q_head;
      mask_r  <= AW'((CW'(1) << lg) - CW'(1));
      slots_r <= CW'(1) << lg;
    end
    h_r <= h_nxt; bi_r <= bi_nxt; idx_r <= idx_nxt; n_r <= n_nxt;
    if (st_r == BK_READ) begin
      occ_rd_r <= occ_mem[idx_r];
      rk_hi_r  <= khi_mem[idx_r];
      rk_lo_r  <= klo_mem[idx_r];
      rf_r     <= fw_mem[idx_r];
      rb_r     <= bw_mem[idx_r];
    end
    if (clearing) occ_mem[clr_r[AW-1:0]] <= 1'b0;
    else if (wr_en) occ_mem[idx_r] <= 1'b1;
    if (wr_en) begin
      khi_mem[idx_r] <= req_r.key_high;
      klo_mem[idx_r] <= req_r.key_low;
      fw_mem[idx_r]  <= req_r.forward_code;
      bw_mem[idx_r]  <= req_r.backward_code;
    end
    if (res_load) begin
      status <= res_st; slot_index <= 12'(res_slot);
      found_forward <= res_f; found_backward <= res_b;
      next_key_high <= req_r.key_high; next_key_low <= req_r.key_low;
    end
    if (!rst_n) begin
      st_r <= BK_IDLE; out_valid <= 1'b0; clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (clearing) clr_r <= clr_r + {{AW{1'b0}}, 1'b1};
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  `include "kmer_hash_table_engine_assert.svh"
  `KHT_ASSERT(a_no_load_over, res_load |-> (!out_valid || !out_stall),
              "result overwritten while stalled")
  `KHT_ASSERT(a_no_work_clear, clearing |-> st_r == BK_IDLE,
              "request taken during clearing pass")
  `KHT_ASSERT(a_probe_bound, st_r == BK_CHECK |-> n_r < slots_r, "probe walk overran")
endmodule

@@ hw/rtl/kmer_hash_table_engine.sv @@
// Top level of the k-mer hash table engine: configuration registers and the two parts.
// Each request is hashed first, one key byte at a time in the shared FNV multiply step,
// then walks the slots, each probe passing through the read, wait and check states, as
// set by the single read port of the slot memory. After reset a clearing pass over every
// slot empties the occupancy memory before the first request is taken; configuration
// writes are taken throughout. Up to two requests wait in the queue between front and back.
module kmer_hash_table_engine import kht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned MAX_BASES   = MaxBasesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key_high,
  input  logic [63:0] in_key_low,
  input  logic [2:0]  in_forward_code,
  input  logic [2:0]  in_backward_code,
  input  logic [1:0]  in_step_base,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [11:0] out_slot_index,
  output logic [2:0]  out_found_forward,
  output logic [2:0]  out_found_backward,
  output logic [63:0] out_next_key_high,
  output logic [63:0] out_next_key_low,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [6:0] kmer_length_r;
  logic [3:0] table_log_r;
  logic       q_valid, q_pop;
  kht_req_t   q_head;

  assign pready = 1'b1;

  // Register reads are decoded by word address.
  always_comb begin
    case (paddr[2])
      RegKmerLength: prdata = {25'd0, kmer_length_r};
      RegTableLog:   prdata = {28'd0, table_log_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r <= 7'd31; table_log_r <= 4'd12;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegKmerLength) kmer_length_r <= pwdata[6:0];
      else table_log_r <= pwdata[3:0];
    end
  end

  kht_front #(.MAX_BASES(MAX_BASES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .op(in_op), .key_high(in_key_high), .key_low(in_key_low),
    .forward_code(in_forward_code), .backward_code(in_backward_code),
    .step_base(in_step_base), .kmer_length(kmer_length_r),
    .q_valid, .q_pop, .q_head
  );

  kht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_head, .table_log_size(table_log_r),
    .out_valid, .out_stall, .status(out_status), .slot_index(out_slot_index),
    .found_forward(out_found_forward), .found_backward(out_found_backward),
    .next_key_high(out_next_key_high), .next_key_low(out_next_key_low)
  );
endmodule

@@ sim/tb_kmer_hash_table_engine.sv @@
// Self-checking testbench for the k-mer hash table engine: directed, extreme-setting and random runs.
`timescale 1ns / 100ps

module tb_kmer_hash_table_engine;
  import kht_pkg::*;

  // Op code 3 is not assigned and must behave as a find that changes nothing.
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned Depth = 4096;

  // One result as the block reports it.
  typedef struct {
    logic [1:0]  status;
    logic [11:0] slot_index;
    logic [2:0]  found_forward;
    logic [2:0]  found_backward;
    logic [63:0] next_key_high;
    logic [63:0] next_key_low;
  } lookup_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [63:0] in_key_high;
  logic [63:0] in_key_low;
  logic [2:0]  in_forward_code;
  logic [2:0]  in_backward_code;
  logic [1:0]  in_step_base;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [11:0] out_slot_index;
  logic [2:0]  out_found_forward;
  logic [2:0]  out_found_backward;
  logic [63:0] out_next_key_high;
  logic [63:0] out_next_key_low;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kmer_hash_table_engine u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_key_high        (in_key_high),
    .in_key_low         (in_key_low),
    .in_forward_code    (in_forward_code),
    .in_backward_code   (in_backward_code),
    .in_step_base       (in_step_base),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_found_forward  (out_found_forward),
    .out_found_backward (out_found_backward),
    .out_next_key_high  (out_next_key_high),
    .out_next_key_low   (out_next_key_low),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // Shadow copy of the configuration registers and of the table contents.
  logic [6:0]   kmer_len_reg;
  logic [3:0]   table_log_reg;
  logic         slot_used   [Depth];
  logic [127:0] slot_key    [Depth];
  logic [2:0]   slot_fwd    [Depth];
  logic [2:0]   slot_bwd    [Depth];

  lookup_result_t pending_results[$];
  int             fail_count;

  // Handshake pressure, changed from phase to phase.
  int gap_pct;
  int stall_pct;
  int stall_left;

  // Keys known to be in the table under the current setting, used to build hits.
  logic [127:0] stored_keys[$];

  always #5 clk = ~clk;

  // Effective key length: zero acts as one base, anything above 64 as 64.
  function automatic int unsigned active_bases();
    int unsigned k;
    k = kmer_len_reg;
    if (k < 1) k = 1;
    if (k > 64) k = 64;
    return k;
  endfunction

  // Effective slot count; oversized tables shrink to the physical depth.
  function automatic int unsigned active_slots();
    int unsigned lg;
    int unsigned n;
    lg = table_log_reg;
    if (lg < 1) lg = 1;
    n = 1 << lg;
    while (n > Depth) n = n >> 1;
    return n;
  endfunction

  // Keeps the first k bases of a 128-bit key, which is top aligned.
  function automatic logic [127:0] clip_bases(logic [127:0] key, int unsigned k);
    logic [127:0] m;
    m = ~({128{1'b1}} >> (2 * k));
    return key & m;
  endfunction

  // FNV-1a over the first ceil(k/4) bytes of the key, most significant byte first.
  function automatic logic [63:0] fnv1a_key(logic [127:0] key, int unsigned k);
    logic [63:0] h;
    int unsigned nbytes;
    nbytes = (k + 3) / 4;
    h = FnvOffset;
    for (int i = 0; i < nbytes; i++) begin
      h = (h ^ {56'd0, key[127 - 8 * i -: 8]}) * FnvPrime;
    end
    return h;
  endfunction

  // Works out the result of one request and updates the shadow table.
  function automatic lookup_result_t hash_table_apply(logic [1:0] op, logic [127:0] key_in,
                                                      logic [2:0] fc, logic [2:0] bc,
                                                      logic [1:0] base);
    lookup_result_t r;
    int unsigned k;
    int unsigned slots;
    int unsigned mask;
    int unsigned idx;
    logic [127:0] key;
    k = active_bases();
    slots = active_slots();
    mask = slots - 1;
    key = clip_bases(key_in, k);
    if (op == OpExtend) begin
      key = clip_bases(key << 2, k);
      key[127 - 2 * (k - 1) -: 2] = base;
    end
    idx = 32'(fnv1a_key(key, k) & 64'(mask));
    r.status = StNotFound;
    r.slot_index = '0;
    r.found_forward = '0;
    r.found_backward = '0;
    r.next_key_high = key[127:64];
    r.next_key_low = key[63:0];
    if (op == OpInsert) begin
      r.status = StFull;
      for (int n = 0; n < slots; n++) begin
        if (!slot_used[idx]) begin
          slot_used[idx] = 1'b1;
          slot_key[idx] = key;
          slot_fwd[idx] = fc;
          slot_bwd[idx] = bc;
          r.status = StDone;
          r.slot_index = 12'(idx);
          r.found_forward = fc;
          r.found_backward = bc;
          break;
        end
        idx = (idx + 1) & mask;
      end
    end else begin
      for (int n = 0; n < slots; n++) begin
        if (!slot_used[idx]) break;
        if (clip_bases(slot_key[idx], k) == key) begin
          r.status = StDone;
          r.slot_index = 12'(idx);
          r.found_forward = slot_fwd[idx];
          r.found_backward = slot_bwd[idx];
          break;
        end
        idx = (idx + 1) & mask;
      end
    end
    return r;
  endfunction

  // A key that, extended by the last base of the target, turns into the target.
  function automatic logic [127:0] key_before(logic [127:0] target, logic [1:0] first);
    return clip_bases({first, target[127:2]}, active_bases());
  endfunction

  function automatic logic [1:0] last_base(logic [127:0] key);
    int unsigned k;
    k = active_bases();
    return key[127 - 2 * (k - 1) -: 2];
  endfunction

  function automatic logic [127:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Inserts a gap with the given percentage; most gaps are short, a few are long.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  // Sends one request and records what the block must answer.
  task automatic send_request(logic [1:0] op, logic [127:0] key, logic [2:0] fc,
                              logic [2:0] bc, logic [1:0] base);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_key_high <= key[127:64];
    in_key_low <= key[63:0];
    in_forward_code <= fc;
    in_backward_code <= bc;
    in_step_base <= base;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(hash_table_apply(op, key, fc, bc, base));
    if (op == OpInsert && pending_results[$].status == StDone) begin
      stored_keys.push_back(clip_bases(key, active_bases()));
    end
    gap = pick_gap(gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every result has come back, then lets the last probe walk settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write through the configuration port: setup cycle, then access cycle.
  task automatic write_reg(logic [0:0] index, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == RegKmerLength) kmer_len_reg = value[6:0];
    else table_log_reg = value[3:0];
  endtask

  // Changes both registers between phases; keys built under the old length are dropped.
  task automatic set_geometry(logic [6:0] k, logic [3:0] lg);
    wait_idle();
    write_reg(RegKmerLength, {25'd0, k});
    write_reg(RegTableLog, {28'd0, lg});
    stored_keys.delete();
  endtask

  // Stray bits, extreme keys, every op, hits through extend and misses at reset settings.
  task automatic test_directed_ops();
    logic [127:0] target;
    gap_pct = 0;
    stall_pct = 0;
    send_request(OpInsert, {128{1'b1}}, 3'd4, 3'd0, 2'd0);
    send_request(OpFind, {128{1'b1}}, 3'd0, 3'd0, 2'd0);
    send_request(OpInsert, '0, 3'd3, 3'd4, 2'd3);
    send_request(OpFind, {64'd0, {64{1'b1}}}, 3'd7, 3'd7, 2'd3);
    target = clip_bases(random_key(), active_bases());
    send_request(OpInsert, target, 3'd1, 3'd2, 2'd1);
    send_request(OpExtend, key_before(target, 2'd3) | 128'd1, 3'd0, 3'd0, last_base(target));
    send_request(OpExtend, {128{1'b1}}, 3'd0, 3'd0, 2'd3);
    send_request(OpExtend, '0, 3'd0, 3'd0, 2'd0);
    send_request(OpUnused, target, 3'd5, 3'd6, 2'd2);
    send_request(OpFind, random_key(), 3'd0, 3'd0, 2'd1);
    send_request(OpInsert, target, 3'd0, 3'd1, 2'd0);
    send_request(OpFind, target, 3'd0, 3'd0, 2'd0);
  endtask

  // Register extremes: tiny tables that fill up, and out-of-range length and size.
  task automatic test_config_extremes();
    set_geometry(7'd1, 4'd1);
    for (int i = 0; i < 4; i++) send_request(OpInsert, {i[1:0], 126'd0}, i[2:0], 3'd4, 2'd0);
    send_request(OpFind, {2'd3, 126'd0}, 3'd0, 3'd0, 2'd0);
    send_request(OpExtend, {2'd2, {126{1'b1}}}, 3'd0, 3'd0, 2'd1);
    set_geometry(7'd0, 4'd0);
    send_request(OpInsert, {2'd2, {126{1'b1}}}, 3'd2, 3'd2, 2'd0);
    send_request(OpFind, {2'd2, 126'd0}, 3'd0, 3'd0, 2'd0);
    set_geometry(7'd127, 4'd15);
    send_request(OpInsert, {128{1'b1}}, 3'd4, 3'd4, 2'd0);
    send_request(OpExtend, {2'd3, {126{1'b1}}}, 3'd0, 3'd0, 2'd3);
    set_geometry(7'd64, 4'd12);
    send_request(OpFind, {128{1'b1}}, 3'd0, 3'd0, 2'd0);
  endtask

  // Random phases: a mix of inserts with finds and extends of stored keys that should hit.
  task automatic test_random_phases();
    logic [6:0] k_list[10] = '{7'd31, 7'd1, 7'd64, 7'd8, 7'd33, 7'd0, 7'd127, 7'd45,
                               7'd20, 7'd63};
    logic [3:0] lg_list[10] = '{4'd12, 4'd1, 4'd4, 4'd6, 4'd9, 4'd2, 4'd13, 4'd15,
                                4'd12, 4'd7};
    logic [127:0] key;
    int pick;
    for (int ph = 0; ph < 10; ph++) begin
      set_geometry(k_list[ph], lg_list[ph]);
      gap_pct = (ph % 3 == 0) ? 0 : 30;
      stall_pct = (ph % 4 == 1) ? 0 : 25;
      for (int n = 0; n < 140; n++) begin
        pick = $urandom_range(99);
        if (pick < 40 || stored_keys.size() == 0) begin
          send_request(OpInsert, random_key(), 3'($urandom_range(4)),
                       3'($urandom_range(4)), 2'($urandom_range(3)));
        end else if (pick < 65) begin
          key = stored_keys[$urandom_range(stored_keys.size() - 1)];
          send_request(OpFind, key | ($urandom_range(1) ? random_key() >> (2 * 64) : '0),
                       3'($urandom_range(4)), 3'($urandom_range(4)),
                       2'($urandom_range(3)));
        end else if (pick < 85) begin
          key = stored_keys[$urandom_range(stored_keys.size() - 1)];
          send_request(OpExtend, key_before(key, 2'($urandom_range(3))),
                       3'($urandom_range(4)), 3'($urandom_range(4)), last_base(key));
        end else begin
          send_request(2'($urandom_range(3, 1)), random_key(), 3'($urandom_range(4)),
                       3'($urandom_range(4)), 2'($urandom_range(3)));
        end
      end
    end
  endtask

  // Result side: random stall, and a check of every accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", exp_r.status, out_status);
        check_field("slot_index", exp_r.slot_index, out_slot_index);
        check_field("found_forward", exp_r.found_forward, out_found_forward);
        check_field("found_backward", exp_r.found_backward, out_found_backward);
        check_field("next_key_high", exp_r.next_key_high, out_next_key_high);
        check_field("next_key_low", exp_r.next_key_low, out_next_key_low);
      end
    end
  end

  // Hard limit, far above the slowest correct run including the clearing pass,
  // even if every request walked the whole table under long stalls.
  initial begin
    #1_000_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OpFind;
    in_key_high = '0;
    in_key_low = '0;
    in_forward_code = '0;
    in_backward_code = '0;
    in_step_base = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    gap_pct = 0;
    stall_pct = 0;
    kmer_len_reg = 7'd31;
    table_log_reg = 4'd12;
    for (int i = 0; i < Depth; i++) slot_used[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_config_extremes();
    test_random_phases();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/kht_pkg.sv
hw/rtl/kht_front.sv
hw/rtl/kht_back.sv
hw/rtl/kmer_hash_table_engine.sv
sim/tb_kmer_hash_table_engine.sv
